>>> sv/udec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udec_pkg: shared types and constants
// Operation record passed from the escape front to the UTF-8 back, character
// constants and hex digit helpers.
// ----------------------------------------------------------------------------
package udec_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // One unit of work for the back end: a byte to feed and/or the end of a string.
  typedef struct packed {
    logic [7:0] data;
    logic       feed;
    logic       last;
  } op_t;

  function automatic logic hex_digit(input logic [7:0] b);
    hex_digit = (b >= 8'd48 && b <= 8'd57) || (b >= 8'd65 && b <= 8'd70) ||
                (b >= 8'd97 && b <= 8'd102);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    if (b >= 8'd97) v = b - 8'd87;
    else if (b >= 8'd65) v = b - 8'd55;
    else v = b - 8'd48;
    hex_value = v[3:0];
  endfunction

endpackage

>>> sv/udec_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udec_front: percent-escape front end
// Takes raw URL bytes, resolves '%XX' and '+', and emits zero to two
// operations per byte for the UTF-8 back end.
// ----------------------------------------------------------------------------
module udec_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            room,
  output logic [1:0]      push_n,
  output udec_pkg::op_t   op0,
  output udec_pkg::op_t   op1
);
  import udec_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PCT  = 3'b010,
    PH_HEX  = 3'b100
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] held, held_next;
  logic       fa_v, fb_v;
  logic [7:0] fa, fb;
  logic       is_hex, plain_pct, plain_feed;
  logic [7:0] plain_byte;
  logic       take;

  assign in_ready = room;
  assign take     = in_valid && room;

  always_comb begin
    is_hex     = hex_digit(in_byte);
    plain_pct  = (in_byte == CH_PERCENT);
    plain_feed = !plain_pct;
    plain_byte = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
    phase_next = phase;
    held_next  = held;
    fa_v = 1'b0; fa = CH_NUL;
    fb_v = 1'b0; fb = CH_NUL;
    case (phase)
      PH_PCT: begin
        if (is_hex) begin
          held_next  = in_byte;
          phase_next = PH_HEX;
        end else begin
          phase_next = plain_pct ? PH_PCT : PH_IDLE;
          fa_v = plain_feed; fa = plain_byte;
        end
      end
      PH_HEX: begin
        phase_next = PH_IDLE;
        fa_v = 1'b1;
        if (is_hex) begin
          fa = {hex_value(held), hex_value(in_byte)};
        end else begin
          // lone digit passes literally, then the byte is handled as plain
          fa = held;
          fb_v = plain_feed; fb = plain_byte;
          phase_next = plain_pct ? PH_PCT : PH_IDLE;
        end
      end
      default: begin
        phase_next = plain_pct ? PH_PCT : PH_IDLE;
        fa_v = plain_feed; fa = plain_byte;
      end
    endcase
    if (in_last) begin
      if (phase_next == PH_HEX) begin
        fa_v = 1'b1; fa = held_next;
      end
      phase_next = PH_IDLE;
    end
    // last flag rides on the final operation of the string
    op0.data = fa;
    op0.feed = fa_v;
    op0.last = in_last && !fb_v;
    op1.data = fb;
    op1.feed = fb_v;
    op1.last = in_last;
    if (!take) push_n = 2'd0;
    else if (fb_v) push_n = 2'd2;
    else if (fa_v || in_last) push_n = 2'd1;
    else push_n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (take) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= held_next;
    end
  end

endmodule

>>> sv/udec_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udec_fifo: operation queue
// Four-entry queue taking up to two operations a cycle and giving one.
// ----------------------------------------------------------------------------
module udec_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_n,
  input  udec_pkg::op_t   op0,
  input  udec_pkg::op_t   op1,
  output logic            room,
  output logic            avail,
  input  logic            pop,
  output udec_pkg::op_t   head
);
  import udec_pkg::*;

  op_t            q [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QCW-1:0] count;
  logic [QAW-1:0] wptr1;

  assign wptr1 = wptr + 1'b1;
  assign room  = (count <= QCW'(QDEPTH - 2));
  assign avail = (count != '0);
  assign head  = q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QAW'(push_n);
      rptr  <= rptr + QAW'(pop);
      count <= count + QCW'(push_n) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q[wptr] <= op0;
    end
    if (push_n == 2'd2) begin
      q[wptr1] <= op1;
    end
  end

endmodule

>>> sv/udec_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udec_back: UTF-8 back end
// Decodes 1 to 6 byte forms without checking continuations, handles the
// end-of-string flush and holds the result in an output register.
// ----------------------------------------------------------------------------
module udec_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            avail,
  input  udec_pkg::op_t   op,
  output logic            pop,
  output logic            out_v,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_flag,
  output logic            out_last
);
  import udec_pkg::*;

  logic [2:0] left, left_next;
  logic [7:0] acc, acc_next;
  logic       emit, flag;
  logic [7:0] ch;
  logic [7:0] b;

  assign b   = op.data;
  assign pop = avail && (!out_v || out_ready);

  always_comb begin
    emit = 1'b0; ch = CH_NUL; flag = 1'b1;
    left_next = left; acc_next = acc;
    if (op.feed) begin
      if (left != 3'd0) begin
        acc_next  = {acc[1:0], b[5:0]};
        left_next = left - 3'd1;
        emit      = (left_next == 3'd0);
        ch        = acc_next;
      end else if (!b[7]) begin
        emit = 1'b1; ch = b;
      end else if (b[7:5] == 3'b110) begin
        acc_next = {3'b0, b[4:0]}; left_next = 3'd1;
      end else if (b[7:4] == 4'b1110) begin
        acc_next = {4'b0, b[3:0]}; left_next = 3'd2;
      end else if (b[7:3] == 5'b11110) begin
        acc_next = {5'b0, b[2:0]}; left_next = 3'd3;
      end else if (b[7:2] == 6'b111110) begin
        acc_next = {6'b0, b[1:0]}; left_next = 3'd4;
      end else if (b[7:1] == 7'b1111110) begin
        acc_next = {7'b0, b[0]}; left_next = 3'd5;
      end else begin
        emit = 1'b1; ch = CH_QMARK;
      end
    end
    if (op.last) begin
      // missing continuation bytes count as zero
      if (left_next != 3'd0) begin
        emit = 1'b1;
        ch   = (left_next == 3'd1) ? {acc_next[1:0], 6'b0} : CH_NUL;
      end else if (!emit) begin
        emit = 1'b1; ch = CH_NUL; flag = 1'b0;
      end
      left_next = 3'd0;
      acc_next  = CH_NUL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left  <= 3'd0;
      acc   <= CH_NUL;
      out_v <= 1'b0;
    end else begin
      if (pop) begin
        left  <= left_next;
        acc   <= acc_next;
        out_v <= emit;
      end else if (out_ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_byte <= ch;
      out_flag <= flag;
      out_last <= op.last;
    end
  end

endmodule

>>> sv/url_percent_and_utf8_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_and_utf8_decoder: URL percent decoder with UTF-8 decoding
// Top level joining the escape front, the operation queue and the UTF-8 back.
// ----------------------------------------------------------------------------
// Takes one byte of URL text per cycle while the queue has room and returns
// decoded characters, each the low 8 bits of a UTF-8 code point. The front
// resolves escapes combinationally and turns each byte into at most two
// queued operations; the back runs one operation per cycle while its output
// register is empty or being taken, so the sustained rate is one byte per
// cycle except where a '%X' cut short by a non-hex byte adds a back-end
// operation. A four-entry queue lets the front keep taking bytes while the
// back or the downstream side stalls. A string whose last byte yields no
// character closes with one end marker (tuser 0, tdata 0, tlast 1).
module url_percent_and_utf8_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] out_flag
  output logic       m_axis_tlast    // out_last
);
  import udec_pkg::*;

  logic [1:0] push_n;
  op_t        op0, op1, head;
  logic       room, avail, pop;

  udec_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .room     (room),
    .push_n   (push_n),
    .op0      (op0),
    .op1      (op1)
  );

  udec_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .op0    (op0),
    .op1    (op1),
    .room   (room),
    .avail  (avail),
    .pop    (pop),
    .head   (head)
  );

  udec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .avail     (avail),
    .op        (head),
    .pop       (pop),
    .out_v     (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_flag  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

>>> sv/udec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udec_checker: port-level checks
// Watches the decoder's ports for reset behaviour, end markers and stalls.
// ----------------------------------------------------------------------------
module udec_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // queue empties on reset, so a request can be taken straight after
  a_ready_after_rst: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready after reset");

  a_no_out_after_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result shown after reset");

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 8'h00))
    else $error("end marker not last or not zero");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind url_percent_and_utf8_decoder udec_checker u_udec_checker (.*);

>>> bench/udec_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udec_stream_checker: result checker for the URL and UTF-8 decoder
// Watches both stream channels. Each accepted request is run through a local
// model of the escape and UTF-8 stages, and the decoded characters it yields
// are queued. Every accepted result is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module udec_stream_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tlast,
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,
  input  logic       m_axis_tuser,
  input  logic       m_axis_tlast,
  output int         errors,
  output int         pending_results
);
  import udec_pkg::*;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_PERCENT,
    ESC_DIGIT
  } esc_state_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_char;
    logic       ends;
  } decoded_t;

  esc_state_t esc_state   = ESC_NONE;
  logic [7:0] first_digit = '0;
  logic [2:0] cont_left   = '0;
  logic [7:0] code_lo     = '0;

  decoded_t decoded_q[$];
  decoded_t step_q[$];

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // letters carry bit 6; their low nibble is one above the digit value minus 10
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    return c[6] ? c[3:0] + 4'd9 : c[3:0];
  endfunction

  task automatic push_char(input logic [7:0] c);
    step_q.push_back(decoded_t'{c, 1'b1, 1'b0});
  endtask

  task automatic utf8_take(input logic [7:0] b);
    if (cont_left != 3'd0) begin
      code_lo   = {code_lo[1:0], b[5:0]};
      cont_left = cont_left - 3'd1;
      if (cont_left == 3'd0) push_char(code_lo);
    end else if (!b[7]) begin
      push_char(b);
    end else if (b[7:5] == 3'b110) begin
      code_lo = {3'b000, b[4:0]}; cont_left = 3'd1;
    end else if (b[7:4] == 4'b1110) begin
      code_lo = {4'b0000, b[3:0]}; cont_left = 3'd2;
    end else if (b[7:3] == 5'b11110) begin
      code_lo = {5'b00000, b[2:0]}; cont_left = 3'd3;
    end else if (b[7:2] == 6'b111110) begin
      code_lo = {6'b000000, b[1:0]}; cont_left = 3'd4;
    end else if (b[7:1] == 7'b1111110) begin
      code_lo = {7'b0000000, b[0]}; cont_left = 3'd5;
    end else begin
      push_char(CH_QMARK);
    end
  endtask

  task automatic take_plain(input logic [7:0] b);
    if (b == CH_PERCENT) esc_state = ESC_PERCENT;
    else if (b == CH_PLUS) utf8_take(CH_SPACE);
    else utf8_take(b);
  endtask

  task automatic decode_request(input logic [7:0] b, input logic is_last);
    logic [7:0] tail;
    step_q.delete();
    case (esc_state)
      ESC_PERCENT: begin
        if (is_hex_char(b)) begin
          first_digit = b;
          esc_state   = ESC_DIGIT;
        end else begin
          esc_state = ESC_NONE;
          take_plain(b);
        end
      end
      ESC_DIGIT: begin
        esc_state = ESC_NONE;
        if (is_hex_char(b)) begin
          utf8_take({nibble_of(first_digit), nibble_of(b)});
        end else begin
          utf8_take(first_digit);
          take_plain(b);
        end
      end
      default: begin
        esc_state = ESC_NONE;
        take_plain(b);
      end
    endcase
    if (is_last) begin
      if (esc_state == ESC_DIGIT) utf8_take(first_digit);
      // missing continuation bytes count as zero
      if (cont_left != 3'd0) begin
        tail = code_lo << (6 * cont_left);
        push_char(tail);
      end
      if (step_q.size() == 0) step_q.push_back(decoded_t'{CH_NUL, 1'b0, 1'b0});
      step_q[step_q.size() - 1].ends = 1'b1;
      esc_state   = ESC_NONE;
      first_digit = '0;
      cont_left   = '0;
      code_lo     = '0;
    end
    foreach (step_q[i]) decoded_q.push_back(step_q[i]);
  endtask

  always @(posedge clk) begin
    decoded_t want;
    decoded_t got;
    if (rst) begin
      esc_state   = ESC_NONE;
      first_digit = '0;
      cont_left   = '0;
      code_lo     = '0;
      decoded_q.delete();
      pending_results <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_request(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got = decoded_t'{m_axis_tdata, m_axis_tuser, m_axis_tlast};
        if (decoded_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with none expected: byte %02h valid %b last %b",
                     $realtime, got.ch, got.is_char, got.ends);
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: expected byte %02h valid %b last %b, got %02h %b %b",
                       $realtime, want.ch, want.is_char, want.ends,
                       got.ch, got.is_char, got.ends);
          end
        end
      end
      pending_results <= decoded_q.size();
    end
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for url_percent_and_utf8_decoder
// Drives directed and random URL strings in bursts, stalls the result side on
// patterns of its own, and gives the verdict from the checker's error and pending-result counts.
// ----------------------------------------------------------------------------
module tb;
  import udec_pkg::*;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  int errors;
  int pending_results;

  int burst_left = 0;
  int bytes_sent = 0;
  int strings    = 0;
  int hold_reqs  = 0;
  int holds_done = 0;
  logic [7:0] text_q[$];

  always #5 clk = ~clk;

  url_percent_and_utf8_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  udec_stream_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .errors          (errors),
    .pending_results (pending_results)
  );

  // one request per call; bursts of random length, random gaps between them
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_last;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic escaped);
    if (escaped) begin
      text_q.push_back(CH_PERCENT);
      text_q.push_back(hex_char(b[7:4]));
      text_q.push_back(hex_char(b[3:0]));
    end else begin
      text_q.push_back(b);
    end
  endtask

  task automatic build_random_text();
    logic [7:0] ones;
    logic [7:0] v;
    logic [7:0] seq[$];
    int n;
    int keep;
    ones = 8'hFF;
    if ($urandom_range(0, 9) == 0) begin
      // pure noise
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(0, 9))
          0, 1: text_q.push_back(8'($urandom_range(0, 127)));
          2:    put_byte(8'($urandom_range(0, 255)), 1'b1);
          3:    text_q.push_back(CH_PLUS);
          4: begin
            // broken escape: '%' with at most one digit, then maybe a byte that is not hex
            text_q.push_back(CH_PERCENT);
            if ($urandom_range(0, 1)) text_q.push_back(hex_char(4'($urandom_range(0, 15))));
            case ($urandom_range(0, 4))
              0: text_q.push_back(CH_PERCENT);
              1: text_q.push_back(CH_PLUS);
              2: text_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
              3: text_q.push_back(8'h67);
              default: ;
            endcase
          end
          default: begin
            n = $urandom_range(1, 6);
            seq.delete();
            if (n == 1) v = 8'($urandom_range(0, 127));
            else v = ~(ones >> n) | (8'($urandom_range(0, 255)) & (ones >> (n + 1)));
            seq.push_back(v);
            repeat (n - 1) begin
              if ($urandom_range(0, 9) == 0) seq.push_back(8'($urandom_range(0, 255)));
              else seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
            end
            keep = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n) : n;
            for (int i = 0; i < keep; i++) put_byte(seq[i], 1'($urandom_range(0, 1)));
          end
        endcase
      end
    end
  endtask

  // result side: random stall patterns, plus one long hold-off on request
  initial begin
    int span;
    int mode;
    m_axis_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_reqs != holds_done) begin
        holds_done++;
        m_axis_tready <= 1'b0;
        repeat (150) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 40);
        for (int i = 0; i < span && hold_reqs == holds_done; i++) begin
          case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= (i % 3 == 0);
            default: m_axis_tready <= 1'($urandom_range(0, 1));
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    push_str("%4a+");   send_text();
    push_str("%zz");    send_text();
    push_str("%4%41");  send_text();  // cut-short escape, then a fresh one
    push_str("%");      send_text();  // lone percent at end: end marker only
    push_str("%F");     send_text();
    text_q = '{8'hFF, 8'h80, 8'hFE};  send_text();
    text_q = '{8'hFC};                send_text();  // six-byte lead left open
    text_q = '{8'h00, 8'h7F};         send_text();
    text_q = '{8'hC3, 8'hA9};         send_text();
    wait_drained();

    while (bytes_sent < 345) begin
      if (strings == 3) hold_reqs <= hold_reqs + 1;
      build_random_text();
      send_text();
      strings++;
      if (strings % 12 == 0) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_results == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
